[rtl/binary_min_heap_queue_macros.svh]
// assertion macros for the heap queue checker
`ifndef BINARY_MIN_HEAP_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define BMHQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define BMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/bmhq_pkg.sv]
// shared types, constants and compare function for the heap queue
package bmhq_pkg;

   localparam int NODE_BITS  = 8;
   localparam int SCORE_BITS = 10;
   localparam int DIST_BITS  = 5;
   localparam int CAPACITY   = 256;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int ADDR_BITS  = $clog2(CAPACITY);
   localparam int ENTRY_BITS = NODE_BITS + SCORE_BITS + DIST_BITS;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2
   } err_code_type;

   typedef struct packed {
      logic [NODE_BITS-1:0]  node;
      logic [SCORE_BITS-1:0] score;
      logic [DIST_BITS-1:0]  distance;
   } entry_type;

   typedef struct packed {
      logic                  req_type;
      logic [NODE_BITS-1:0]  new_node;
      logic [SCORE_BITS-1:0] new_score;
      logic [DIST_BITS-1:0]  new_dist;
   } req_payload_type;

   typedef struct packed {
      logic [NODE_BITS-1:0]  pop_node;
      logic [SCORE_BITS-1:0] pop_score;
      logic [DIST_BITS-1:0]  pop_dist;
      logic                  pop_valid;
      err_code_type          error_code;
      logic [COUNT_BITS-1:0] entry_count;
      logic [NODE_BITS-1:0]  top_node;
      logic [SCORE_BITS-1:0] top_score;
      logic [DIST_BITS-1:0]  top_dist;
      logic                  is_empty;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic flag_empty;
      logic flag_full;
      logic start_push;
      logic start_pop;
      logic take_last;
      logic up_read;
      logic up_step;
      logic dn_read_l;
      logic dn_capture_l;
      logic dn_step;
      logic place;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic k_is_root;
      logic no_child;
      logic parent_after;
      logic child_wins;
      logic rsp_busy;
   } status_type;

   // true when a is served after b
   function automatic logic entry_after(entry_type a, entry_type b);
      entry_after = (a.score > b.score) ||
                    ((a.score == b.score) && (a.distance > b.distance));
   endfunction

endpackage

[rtl/bmhq_ram.sv]
// generic single write port, single read port ram with registered read
module bmhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bmhq_ctrl.sv]
// sequencer for push sift-up and pop sift-down
module bmhq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_is_pop,
   output logic                 req_ready,
   input  bmhq_pkg::status_type status,
   output bmhq_pkg::cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_UP_RD    = 9'b000000010,
      S_UP_CMP   = 9'b000000100,
      S_POP_LAST = 9'b000001000,
      S_DN_RDL   = 9'b000010000,
      S_DN_RDR   = 9'b000100000,
      S_DN_CMP   = 9'b001000000,
      S_FINISH   = 9'b010000000,
      S_SPARE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (req_is_pop == bmhq_pkg::REQ_POP) begin
                  if (status.count_zero) begin
                     cmd.flag_empty = 1'b1;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.start_pop = 1'b1;
                     state_in      = S_POP_LAST;
                  end
               end else begin
                  if (status.count_full) begin
                     cmd.flag_full = 1'b1;
                     state_in      = S_FINISH;
                  end else begin
                     cmd.start_push = 1'b1;
                     state_in       = S_UP_RD;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (status.k_is_root) begin
               cmd.place = 1'b1;
               state_in  = S_FINISH;
            end else begin
               cmd.up_read = 1'b1;
               state_in    = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (status.parent_after) begin
               cmd.up_step = 1'b1;
               state_in    = S_UP_RD;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_FINISH;
            end
         end
         S_POP_LAST: begin
            cmd.take_last = 1'b1;
            state_in      = S_DN_RDL;
         end
         S_DN_RDL: begin
            if (status.no_child) begin
               cmd.place = 1'b1;
               state_in  = S_FINISH;
            end else begin
               cmd.dn_read_l = 1'b1;
               state_in      = S_DN_RDR;
            end
         end
         S_DN_RDR: begin
            cmd.dn_capture_l = 1'b1;
            state_in         = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (status.child_wins) begin
               cmd.dn_step = 1'b1;
               state_in    = S_DN_RDL;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

[rtl/bmhq_dpath.sv]
// heap store, slot pointer, count, root copy and result register
module bmhq_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  bmhq_pkg::req_payload_type req_data,
   input  bmhq_pkg::cmd_type         cmd,
   output bmhq_pkg::status_type      status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bmhq_pkg::rsp_payload_type rsp_data
);

   localparam int CW = bmhq_pkg::COUNT_BITS;
   localparam int AW = bmhq_pkg::ADDR_BITS;

   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           k_ff, k_in;
   bmhq_pkg::entry_type     e_ff, e_in;
   bmhq_pkg::entry_type     top_ff, top_in;
   bmhq_pkg::entry_type     left_ff, left_in;
   logic                    has_right_ff, has_right_in;
   bmhq_pkg::entry_type     popped_ff, popped_in;
   logic                    pop_valid_ff, pop_valid_in;
   bmhq_pkg::err_code_type  err_ff, err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   bmhq_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [CW:0]             k_dbl;
   logic [CW-1:0]           left_slot;
   logic [CW-1:0]           right_slot;
   logic                    right_smaller;
   bmhq_pkg::entry_type     rd_entry;
   bmhq_pkg::entry_type     chosen;
   bmhq_pkg::entry_type     wr_entry;
   logic [CW-1:0]           rd_slot;
   logic                    rd_en;
   logic                    wr_en;
   logic [bmhq_pkg::ENTRY_BITS-1:0] rd_raw;

   // one-based slot to zero-based ram address
   function automatic logic [AW-1:0] slot_addr(logic [CW-1:0] slot);
      logic [CW-1:0] z;
      z = slot - 1'b1;
      slot_addr = z[AW-1:0];
   endfunction

   assign k_dbl      = {k_ff, 1'b0};
   assign left_slot  = k_dbl[CW-1:0];
   assign right_slot = left_slot + 1'b1;
   assign rd_entry   = bmhq_pkg::entry_type'(rd_raw);

   // left wins ties between the children
   assign right_smaller = has_right_ff && bmhq_pkg::entry_after(left_ff, rd_entry);
   assign chosen        = right_smaller ? rd_entry : left_ff;

   always_comb begin
      rd_en   = 1'b0;
      rd_slot = count_ff;
      if (cmd.start_pop) begin
         rd_en   = 1'b1;
         rd_slot = count_ff;
      end else if (cmd.up_read) begin
         rd_en   = 1'b1;
         rd_slot = k_ff >> 1;
      end else if (cmd.dn_read_l) begin
         rd_en   = 1'b1;
         rd_slot = left_slot;
      end else if (cmd.dn_capture_l) begin
         rd_en   = has_right_in;
         rd_slot = right_slot;
      end
   end

   assign wr_en = cmd.place | cmd.up_step | cmd.dn_step;

   always_comb begin
      if (cmd.place) begin
         wr_entry = e_ff;
      end else if (cmd.up_step) begin
         wr_entry = rd_entry;
      end else begin
         wr_entry = chosen;
      end
   end

   bmhq_ram #(
      .WIDTH (bmhq_pkg::ENTRY_BITS),
      .DEPTH (bmhq_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_addr(k_ff)),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (slot_addr(rd_slot)),
      .rd_data (rd_raw)
   );

   always_comb begin
      count_in     = count_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      top_in       = top_ff;
      left_in      = left_ff;
      has_right_in = has_right_ff;
      popped_in    = popped_ff;
      pop_valid_in = pop_valid_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;

      if (cmd.load_req) begin
         e_in.node     = req_data.new_node;
         e_in.score    = req_data.new_score;
         e_in.distance = req_data.new_dist;
         popped_in     = '0;
         pop_valid_in  = 1'b0;
         err_in        = bmhq_pkg::ERR_OK;
      end
      if (cmd.flag_empty) begin
         err_in = bmhq_pkg::ERR_EMPTY;
      end
      if (cmd.flag_full) begin
         err_in = bmhq_pkg::ERR_FULL;
      end
      if (cmd.start_push) begin
         count_in = count_ff + 1'b1;
         k_in     = count_ff + 1'b1;
      end
      if (cmd.take_last) begin
         e_in         = rd_entry;
         popped_in    = top_ff;
         pop_valid_in = 1'b1;
         count_in     = count_ff - 1'b1;
         k_in         = CW'(1);
      end
      if (cmd.up_step) begin
         k_in = k_ff >> 1;
      end
      if (cmd.dn_capture_l) begin
         left_in      = rd_entry;
         has_right_in = (k_dbl < {1'b0, count_ff});
      end
      if (cmd.dn_step) begin
         k_in = right_smaller ? right_slot : left_slot;
      end
      // root copy follows every write to slot one
      if (wr_en && (k_ff == CW'(1))) begin
         top_in = wr_entry;
      end
      if (cmd.finish) begin
         rsp_valid_in        = 1'b1;
         rsp_in.pop_node     = popped_ff.node;
         rsp_in.pop_score    = popped_ff.score;
         rsp_in.pop_dist     = popped_ff.distance;
         rsp_in.pop_valid    = pop_valid_ff;
         rsp_in.error_code   = err_ff;
         rsp_in.entry_count  = count_ff;
         rsp_in.is_empty     = (count_ff == '0);
         if (count_ff == '0) begin
            rsp_in.top_node  = '0;
            rsp_in.top_score = '0;
            rsp_in.top_dist  = '0;
         end else begin
            rsp_in.top_node  = top_ff.node;
            rsp_in.top_score = top_ff.score;
            rsp_in.top_dist  = top_ff.distance;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff         <= k_in;
      e_ff         <= e_in;
      top_ff       <= top_in;
      left_ff      <= left_in;
      has_right_ff <= has_right_in;
      popped_ff    <= popped_in;
      pop_valid_ff <= pop_valid_in;
      err_ff       <= err_in;
      rsp_ff       <= rsp_in;
   end

   assign status.count_zero   = (count_ff == '0);
   assign status.count_full   = (count_ff == CW'(bmhq_pkg::CAPACITY));
   assign status.k_is_root    = (k_ff == CW'(1));
   assign status.no_child     = (k_dbl > {1'b0, count_ff});
   assign status.parent_after = bmhq_pkg::entry_after(rd_entry, e_ff);
   assign status.child_wins   = bmhq_pkg::entry_after(e_ff, chosen);
   assign status.rsp_busy     = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/binary_min_heap_queue.sv]
// top level of the binary min-heap priority queue
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_ready  req_data  (push or pop, new entry)
//   rsp      out  rsp_valid / rsp_ready  rsp_data  (popped entry, top, count, error)
//
// one item at a time; a push passes S_UP_RD and S_UP_CMP per level it climbs,
// a pop S_DN_RDL, S_DN_RDR and S_DN_CMP per level it sinks, set by the single read port
// of the heap ram (one registered read per parent, two per pair of children)
// errored items (pop on empty, push on full) go from idle straight to S_FINISH
// a finished result waits in the output register; the next item is taken
// while it waits and only holds at its own end if the result is still there
// synchronous active-high reset empties the queue; the store needs no clearing
module binary_min_heap_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bmhq_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bmhq_pkg::rsp_payload_type rsp_data
);

   // command and status between sequencer and datapath
   bmhq_pkg::cmd_type    cmd;
   bmhq_pkg::status_type status;

   // sequencer: walks the sift one level at a time
   bmhq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_is_pop (req_data.req_type),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: heap ram, hole pointer, entry count, root copy, result register
   bmhq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/bmhq_checker.sv]
// port-level checks for the heap queue, bound to the top level
`include "binary_min_heap_queue_macros.svh"

module bmhq_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input bmhq_pkg::req_payload_type req_data,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input bmhq_pkg::rsp_payload_type rsp_data
);

   `BMHQ_ASSERT_NOW(a_empty_matches_count, rsp_valid, rsp_data.is_empty == (rsp_data.entry_count == '0), "is_empty disagrees with entry_count")

   `BMHQ_ASSERT_NOW(a_empty_top_zero, rsp_valid && rsp_data.is_empty, rsp_data.top_node == '0 && rsp_data.top_score == '0 && rsp_data.top_dist == '0, "top fields not cleared on empty queue")

   `BMHQ_ASSERT_NOW(a_pop_valid_no_error, rsp_valid && rsp_data.pop_valid, rsp_data.error_code == bmhq_pkg::ERR_OK, "removed item reported with an error")

   `BMHQ_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "new item taken while previous item still in work")

   `BMHQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result dropped or changed")

endmodule

bind binary_min_heap_queue bmhq_checker u_checker (.*);

[sim/heap_queue_checker.sv]
// checker for the heap queue: predicts the result of each request and compares it on arrival
`timescale 1ns / 100ps

module heap_queue_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  bmhq_pkg::req_payload_type req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  bmhq_pkg::rsp_payload_type rsp_data,
   output int                        mismatches,
   output int                        outstanding,
   output int                        requests_seen,
   output int                        entries_removed,
   output int                        full_refusals,
   output int                        empty_pops,
   output int                        peak_size
);

   // one-based heap image, only slots 1..heap_size are ever read
   bmhq_pkg::entry_type       heap_slots [1:bmhq_pkg::CAPACITY];
   int unsigned               heap_size;
   bmhq_pkg::rsp_payload_type predicted_replies [$];

   // a sits below b: higher score, or same score and farther away
   function automatic bit sits_below(bmhq_pkg::entry_type a, bmhq_pkg::entry_type b);
      return {a.score, a.distance} > {b.score, b.distance};
   endfunction

   function automatic bmhq_pkg::rsp_payload_type serve_request(
      bmhq_pkg::req_payload_type r);
      bmhq_pkg::rsp_payload_type res;
      bmhq_pkg::entry_type       moved;
      int unsigned               k;
      int unsigned               c;
      bit                        sinking;
      res = '0;
      res.error_code = bmhq_pkg::ERR_OK;
      if (r.req_type == bmhq_pkg::REQ_PUSH) begin
         if (heap_size == bmhq_pkg::CAPACITY) begin
            res.error_code = bmhq_pkg::ERR_FULL;
            full_refusals++;
         end else begin
            heap_size++;
            k = heap_size;
            heap_slots[k].node     = r.new_node;
            heap_slots[k].score    = r.new_score;
            heap_slots[k].distance = r.new_dist;
            while (k > 1 && sits_below(heap_slots[k / 2], heap_slots[k])) begin
               moved             = heap_slots[k];
               heap_slots[k]     = heap_slots[k / 2];
               heap_slots[k / 2] = moved;
               k                 = k / 2;
            end
         end
      end else begin
         if (heap_size == 0) begin
            res.error_code = bmhq_pkg::ERR_EMPTY;
            empty_pops++;
         end else begin
            res.pop_node  = heap_slots[1].node;
            res.pop_score = heap_slots[1].score;
            res.pop_dist  = heap_slots[1].distance;
            res.pop_valid = 1'b1;
            entries_removed++;
            heap_slots[1] = heap_slots[heap_size];
            heap_size--;
            k       = 1;
            sinking = 1'b1;
            while (sinking && 2 * k <= heap_size) begin
               c = 2 * k;
               // right child only when strictly smaller, so equal children go left
               if (c < heap_size && sits_below(heap_slots[c], heap_slots[c + 1]))
                  c++;
               if (sits_below(heap_slots[k], heap_slots[c])) begin
                  moved         = heap_slots[k];
                  heap_slots[k] = heap_slots[c];
                  heap_slots[c] = moved;
                  k             = c;
               end else begin
                  sinking = 1'b0;
               end
            end
         end
      end
      res.entry_count = bmhq_pkg::COUNT_BITS'(heap_size);
      if (heap_size > 0) begin
         res.top_node  = heap_slots[1].node;
         res.top_score = heap_slots[1].score;
         res.top_dist  = heap_slots[1].distance;
      end else begin
         res.is_empty = 1'b1;
      end
      if (heap_size > peak_size)
         peak_size = heap_size;
      return res;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch_channels
      bmhq_pkg::rsp_payload_type want;
      if (reset) begin
         heap_size = 0;
         predicted_replies.delete();
         outstanding = 0;
      end else begin
         // predict first, so a result in the same cycle still finds its item queued
         if (req_valid && req_ready) begin
            predicted_replies.push_back(serve_request(req_data));
            requests_seen++;
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_replies.size() == 0) begin
               $display("%0t: result arrived with no request outstanding", $time);
               mismatches++;
            end else begin
               want = predicted_replies.pop_front();
               check_field("pop_node",    32'(want.pop_node),    32'(rsp_data.pop_node));
               check_field("pop_score",   32'(want.pop_score),   32'(rsp_data.pop_score));
               check_field("pop_dist",    32'(want.pop_dist),    32'(rsp_data.pop_dist));
               check_field("pop_valid",   32'(want.pop_valid),   32'(rsp_data.pop_valid));
               check_field("error_code",  32'(want.error_code),  32'(rsp_data.error_code));
               check_field("entry_count", 32'(want.entry_count), 32'(rsp_data.entry_count));
               check_field("top_node",    32'(want.top_node),    32'(rsp_data.top_node));
               check_field("top_score",   32'(want.top_score),   32'(rsp_data.top_score));
               check_field("top_dist",    32'(want.top_dist),    32'(rsp_data.top_dist));
               check_field("is_empty",    32'(want.is_empty),    32'(rsp_data.is_empty));
            end
         end
         outstanding = predicted_replies.size();
      end
   end

endmodule

[sim/tb_top.sv]
// testbench top for the heap queue: drives requests, paces results and gives the verdict
`timescale 1ns / 100ps

module tb_top;

   // a full receiver hold-off plus the longest sender gap stays far below this
   localparam int IDLE_LIMIT    = 2000;
   // deepest pop sinks seven levels
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_AT       = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASES        = 9;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   bmhq_pkg::req_payload_type req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   bmhq_pkg::rsp_payload_type rsp_data;

   int mismatches;
   int outstanding;
   int requests_seen;
   int entries_removed;
   int full_refusals;
   int empty_pops;
   int peak_size;
   int idle_cycles = 0;

   // random part: items per phase and the share of pops in each
   // balanced, filling, deep mix, fill past full, churn at full, drain past empty,
   // popping, refilling, balanced
   int phase_len     [PHASES] = '{170, 250, 200, 270, 20, 270, 150, 150, 150};
   int phase_pop_pct [PHASES] = '{ 50,  25,  50,   0, 50, 100,  75,  25,  50};

   always #5 clock = ~clock;

   binary_min_heap_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   heap_queue_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .requests_seen   (requests_seen),
      .entries_removed (entries_removed),
      .full_refusals   (full_refusals),
      .empty_pops      (empty_pops),
      .peak_size       (peak_size)
   );

   // mostly no pause or a short one, now and then a long one
   function automatic int pause_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 88)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // scores crowd both ends often, so equal scores and the distance tie-break come up
   function automatic logic [bmhq_pkg::SCORE_BITS-1:0] pick_score();
      int unsigned roll;
      roll = $urandom_range(0, 3);
      if (roll == 0)
         return bmhq_pkg::SCORE_BITS'($urandom_range(0, 3));
      if (roll == 1)
         return bmhq_pkg::SCORE_BITS'($urandom_range((1 << bmhq_pkg::SCORE_BITS) - 4,
                                                     (1 << bmhq_pkg::SCORE_BITS) - 1));
      return bmhq_pkg::SCORE_BITS'($urandom);
   endfunction

   // a narrow distance now and then gives fully equal keys
   function automatic logic [bmhq_pkg::DIST_BITS-1:0] pick_dist();
      if ($urandom_range(0, 3) == 0)
         return bmhq_pkg::DIST_BITS'($urandom_range(0, 1));
      return bmhq_pkg::DIST_BITS'($urandom);
   endfunction

   // present one item and hold it until the block takes it
   task automatic offer_item(input logic kind,
                             input logic [bmhq_pkg::NODE_BITS-1:0] node,
                             input logic [bmhq_pkg::SCORE_BITS-1:0] score,
                             input logic [bmhq_pkg::DIST_BITS-1:0] distance);
      bmhq_pkg::req_payload_type item;
      item.req_type  = kind;
      item.new_node  = node;
      item.new_score = score;
      item.new_dist  = distance;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      logic kind;
      bit   steady;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part
      // pop on an empty queue, with an all-ones payload that must be ignored
      offer_item(bmhq_pkg::REQ_POP, 8'hFF, 10'h3FF, 5'h1F);
      // largest keys, then smallest keys taking the top
      offer_item(bmhq_pkg::REQ_PUSH, 8'hFF, 10'h3FF, 5'h1F);
      offer_item(bmhq_pkg::REQ_PUSH, 8'h00, 10'h000, 5'h00);
      // same score as the top, decided by distance
      offer_item(bmhq_pkg::REQ_PUSH, 8'hAA, 10'h000, 5'h1F);
      offer_item(bmhq_pkg::REQ_PUSH, 8'h55, 10'h000, 5'h01);
      // fully equal keys under different ids
      offer_item(bmhq_pkg::REQ_PUSH, 8'h80, 10'h200, 5'h10);
      offer_item(bmhq_pkg::REQ_PUSH, 8'h01, 10'h200, 5'h10);
      offer_item(bmhq_pkg::REQ_PUSH, 8'h7F, 10'h001, 5'h00);
      // drain all seven in order, then one pop too many
      repeat (8)
         offer_item(bmhq_pkg::REQ_POP, bmhq_pkg::NODE_BITS'($urandom), pick_score(),
                    pick_dist());
      // root sinking onto two equal children must take the left one
      offer_item(bmhq_pkg::REQ_PUSH, 8'h10, 10'd100, 5'd5);
      offer_item(bmhq_pkg::REQ_PUSH, 8'h11, 10'd200, 5'd5);
      offer_item(bmhq_pkg::REQ_PUSH, 8'h12, 10'd200, 5'd5);
      offer_item(bmhq_pkg::REQ_PUSH, 8'h13, 10'd900, 5'd0);
      offer_item(bmhq_pkg::REQ_POP, 8'h00, 10'h000, 5'h00);

      // random part, phase by phase; some phases run back to back with no gaps
      for (int p = 0; p < PHASES; p++) begin
         steady = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < phase_len[p]; n++) begin
            if (!steady)
               idle_sender(pause_length());
            kind = ($urandom_range(1, 100) <= phase_pop_pct[p]) ?
                   bmhq_pkg::REQ_POP : bmhq_pkg::REQ_PUSH;
            offer_item(kind, bmhq_pkg::NODE_BITS'($urandom), pick_score(), pick_dist());
         end
      end
      req_valid <= 1'b0;

      // wait so the checker has taken the last item before its count is read
      @(posedge clock);
      wait (outstanding == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d entries popped, %0d pops on an empty queue,",
               requests_seen, entries_removed, empty_pops);
      $display("%0d pushes refused when full, depth peaked at %0d of %0d, one long hold-off",
               full_refusals, peak_size, bmhq_pkg::CAPACITY);
      if (mismatches == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // result side: random ready pattern, plus one long hold-off so the block backs up
   initial begin : rsp_pacing
      int run_len;
      int gap;
      int waited;
      bit held;
      waited = 0;
      held   = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held && waited >= HOLD_AT) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         // mostly short bursts of ready, sometimes a long stretch with no stall
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         gap = pause_length();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         waited += run_len + gap;
      end
   end

   // watchdog: cycles in which no item moves on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no item moved for %0d cycles, %0d results still owed",
                  $time, IDLE_LIMIT, outstanding);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
